// ===== design/nms_pkg.sv =====
// ----------------------------------------------------------------------------
// nms_pkg
// Shared word types and the cathode code helper for the nixie multiplex driver.
// ----------------------------------------------------------------------------
package nms_pkg;

  localparam int unsigned DigitW   = 4;
  localparam int unsigned CodeW    = 10;
  localparam int unsigned ShiftLen = 24;
  localparam int unsigned CntW     = 5;
  localparam logic [DigitW-1:0] DigitBlank = 4'd10;
  localparam logic [2:0] SelNone  = 3'd0;
  localparam logic [2:0] SelOne   = 3'd1;
  localparam logic [2:0] SelTwo   = 3'd2;
  localparam logic [2:0] SelThree = 3'd3;
  localparam logic [2:0] SelAll   = 3'd4;

  typedef struct packed {
    logic              display_enable;
    logic              blink_phase;
    logic [2:0]        blank_select;
    logic              colon_enable;
    logic [DigitW-1:0] digit_0;
    logic [DigitW-1:0] digit_1;
    logic [DigitW-1:0] digit_2;
    logic [DigitW-1:0] digit_3;
    logic [DigitW-1:0] digit_4;
    logic [DigitW-1:0] digit_5;
  } in_word_t;

  typedef struct packed {
    logic [2:0] anode_lines;
    logic       dot_left;
    logic       dot_right;
    logic       shift_valid;
    logic       serial_bit;
    logic       latch_strobe;
    logic       run_last;
  } out_word_t;

  typedef struct packed {
    logic                 single;
    logic [2:0]           anode;
    logic                 dot_left;
    logic                 dot_right;
    logic [2*CodeW-1:0]   cathode;
  } cmd_t;

  function automatic logic [CodeW-1:0] onehot10(input logic [DigitW-1:0] v);
    logic [CodeW-1:0] code;
    code = '0;
    if (v < DigitBlank) begin
      code = CodeW'(1) << v;
    end
    return code;
  endfunction

endpackage

// ===== design/nms_front.sv =====
// ----------------------------------------------------------------------------
// nms_front
// Accepts multiplex ticks, tracks the phase and anode state, and turns each
// tick into one command word for the serializer.
// ----------------------------------------------------------------------------
module nms_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            accept,
  input  nms_pkg::in_word_t in_word,
  output nms_pkg::cmd_t   cmd
);

  logic       six_r;
  logic [2:0] phase_r, phase_nxt;
  logic [2:0] anode_r, anode_nxt;
  logic       write_ph;
  logic [1:0] tube;
  logic [nms_pkg::DigitW-1:0] v1, v2;
  logic [2:0] modulus;
  logic [2:0] ph_inc;

  always_comb begin
    write_ph = (phase_r == 3'd0) || (phase_r == 3'd2) || (six_r && phase_r == 3'd4);
    tube     = phase_r[2:1];
    modulus  = six_r ? 3'd6 : 3'd4;
    ph_inc   = 3'(phase_r + 3'd1);
    phase_nxt = (ph_inc >= modulus) ? 3'd0 : ph_inc;

    unique case (tube)
      2'd0: v1 = in_word.digit_5;
      2'd1: v1 = in_word.digit_4;
      default: v1 = in_word.digit_3;
    endcase
    if (six_r) begin
      unique case (tube)
        2'd0: v2 = in_word.digit_2;
        2'd1: v2 = in_word.digit_1;
        default: v2 = in_word.digit_0;
      endcase
    end else begin
      unique case (tube)
        2'd0: v2 = in_word.digit_3;
        default: v2 = in_word.digit_2;
      endcase
    end

    if (in_word.blink_phase) begin
      if (in_word.blank_select == nms_pkg::SelAll) begin
        v1 = nms_pkg::DigitBlank;
        v2 = nms_pkg::DigitBlank;
      end else if (six_r) begin
        if (in_word.blank_select == nms_pkg::SelOne && (tube == 2'd0 || tube == 2'd1)) begin
          v1 = nms_pkg::DigitBlank;
        end else if (in_word.blank_select == nms_pkg::SelTwo && tube == 2'd2) begin
          v1 = nms_pkg::DigitBlank;
        end else if (in_word.blank_select == nms_pkg::SelTwo && tube == 2'd0) begin
          v2 = nms_pkg::DigitBlank;
        end else if (in_word.blank_select == nms_pkg::SelThree &&
                     (tube == 2'd1 || tube == 2'd2)) begin
          v2 = nms_pkg::DigitBlank;
        end
      end else begin
        if (in_word.blank_select == nms_pkg::SelOne) begin
          v1 = nms_pkg::DigitBlank;
        end else if (in_word.blank_select == nms_pkg::SelTwo) begin
          v2 = nms_pkg::DigitBlank;
        end
      end
    end

    anode_nxt = anode_r;
    if (write_ph) begin
      anode_nxt = in_word.display_enable ? 3'(3'b001 << tube) : 3'd0;
    end

    cmd.single    = !(write_ph && in_word.display_enable);
    cmd.anode     = write_ph ? anode_nxt : anode_r;
    cmd.dot_left  = in_word.colon_enable && (phase_r == 3'd2);
    cmd.dot_right = in_word.colon_enable && (phase_r == 3'd1);
    cmd.cathode   = {nms_pkg::onehot10(v2), nms_pkg::onehot10(v1)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      six_r   <= 1'b1;
      phase_r <= 3'd0;
      anode_r <= 3'd0;
    end else begin
      if (cfg_we) begin
        six_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        anode_r <= anode_nxt;
      end
    end
  end

endmodule

// ===== design/nms_fifo.sv =====
// ----------------------------------------------------------------------------
// nms_fifo
// Small command queue between the tick front end and the serializer.
// ----------------------------------------------------------------------------
module nms_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nms_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output nms_pkg::cmd_t dout,
  output logic          empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  nms_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== design/nms_back.sv =====
// ----------------------------------------------------------------------------
// nms_back
// Serializer: plays each command out as one result word, or as 24 shift
// words with the latch and the anode on the last.
// ----------------------------------------------------------------------------
module nms_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  nms_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output nms_pkg::out_word_t  out_word
);

  localparam logic [nms_pkg::CntW-1:0] LastCnt = nms_pkg::CntW'(nms_pkg::ShiftLen - 1);

  logic                          busy_r, busy_nxt;
  logic                          single_r, single_nxt;
  logic [2:0]                    anode_r, anode_nxt;
  logic                          dl_r, dl_nxt;
  logic                          dr_r, dr_nxt;
  logic [nms_pkg::ShiftLen-1:0]  sr_r, sr_nxt;
  logic [nms_pkg::CntW-1:0]      cnt_r, cnt_nxt;
  logic                          fire, last, take;

  always_comb begin
    last = single_r || (cnt_r == LastCnt);
    fire = out_pop && busy_r;
    take = !busy_r || (fire && last);
    q_pop = take && !q_empty;

    busy_nxt   = busy_r;
    single_nxt = single_r;
    anode_nxt  = anode_r;
    dl_nxt     = dl_r;
    dr_nxt     = dr_r;
    sr_nxt     = sr_r;
    cnt_nxt    = cnt_r;

    if (q_pop) begin
      busy_nxt   = 1'b1;
      single_nxt = q_cmd.single;
      anode_nxt  = q_cmd.anode;
      dl_nxt     = q_cmd.dot_left;
      dr_nxt     = q_cmd.dot_right;
      sr_nxt     = ~{4'h0, q_cmd.cathode};
      cnt_nxt    = '0;
    end else if (fire && last) begin
      busy_nxt = 1'b0;
    end else if (fire) begin
      sr_nxt  = {sr_r[nms_pkg::ShiftLen-2:0], 1'b0};
      cnt_nxt = nms_pkg::CntW'(cnt_r + 1'b1);
    end

    out_empty             = !busy_r;
    out_word.anode_lines  = last ? anode_r : 3'd0;
    out_word.dot_left     = dl_r;
    out_word.dot_right    = dr_r;
    out_word.shift_valid  = !single_r;
    out_word.serial_bit   = !single_r && sr_r[nms_pkg::ShiftLen-1];
    out_word.latch_strobe = !single_r && (cnt_r == LastCnt);
    out_word.run_last     = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    single_r <= single_nxt;
    anode_r  <= anode_nxt;
    dl_r     <= dl_nxt;
    dr_r     <= dr_nxt;
    sr_r     <= sr_nxt;
    cnt_r    <= cnt_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !single_r |-> cnt_r <= LastCnt)
    else $error("shift count beyond last bit");

  a_latch_last: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_word.latch_strobe |-> out_word.run_last)
    else $error("latch strobe on a word that does not end the run");

  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !last |=> busy_r && !single_r && cnt_r == $past(cnt_r) + 1'b1)
    else $error("shift run broke off early");

  a_anode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot0(out_word.anode_lines))
    else $error("more than one anode raised");

endmodule

// ===== design/nixie_multiplex_serial_driver.sv =====
// ----------------------------------------------------------------------------
// nixie_multiplex_serial_driver
// Nixie tube multiplexer with a 24-bit serial cathode register.
// ----------------------------------------------------------------------------
// A tick that writes a tube with the display enabled produces 24 result words,
// one per cycle while out_pop is held, since the serializer moves one cathode
// bit per shift clock; every other tick produces one result word. Ticks are taken
// one per cycle while the command queue of QUEUE_DEPTH entries has room.
// QUEUE_DEPTH must be a power of two of at least two.
module nixie_multiplex_serial_driver #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  nms_pkg::in_word_t  in_word,
  output logic               out_empty,
  input  logic               out_pop,
  output nms_pkg::out_word_t out_word
);

  nms_pkg::cmd_t front_cmd;
  nms_pkg::cmd_t q_cmd;
  logic          q_full, q_empty, q_pop;
  logic          accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  nms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_word   (in_word),
    .cmd       (front_cmd)
  );

  nms_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_cmd),
    .empty (q_empty)
  );

  nms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule
